// File: hw/rtl/osc_msp_pkg.sv
// osc message stream parser: shared types, codes and default sizes
package osc_msp_pkg;

    localparam int DEF_ADDRESS_SIZE = 64;
    localparam int DEF_MAX_ARGS     = 8;
    localparam int DEF_MAX_PACKET   = 1024;

    localparam logic [7:0] CH_NULL  = 8'h00;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_INT   = 8'h69;
    localparam logic [7:0] CH_FLOAT = 8'h66;
    localparam logic [7:0] CH_STR   = 8'h73;

    typedef logic [1:0] t_tag;
    localparam t_tag TAG_INT   = 2'd0;
    localparam t_tag TAG_FLOAT = 2'd1;
    localparam t_tag TAG_STR   = 2'd2;
    localparam t_tag TAG_OTHER = 2'd3;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_INT    = 2'd0;
    localparam t_kind KIND_FLOAT  = 2'd1;
    localparam t_kind KIND_STR    = 2'd2;
    localparam t_kind KIND_STATUS = 2'd3;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] arg_value;
        logic [9:0]  string_offset;
        logic [9:0]  string_length;
        logic [2:0]  arg_position;
        logic        accepted;
        logic [3:0]  argument_total;
        logic [5:0]  address_length;
        logic        run_end;
    } t_result;

endpackage

// File: hw/rtl/osc_message_stream_parser_unit.sv
// osc message stream parser: byte-wide parse logic and result queue
// results are registered into the result queue, whose head entry drives the outputs
// throughput: one byte per cycle while o_in_ready is high; a byte that yields an
// argument and a status pushes two entries into the four-entry result queue
// input ready while at least two queue entries are free
// synchronous active-low reset clears the parser registers and empties the queue; the tag store is not reset
module osc_message_stream_parser_unit #(
    parameter int ADDRESS_SIZE = osc_msp_pkg::DEF_ADDRESS_SIZE,
    parameter int MAX_ARGS     = osc_msp_pkg::DEF_MAX_ARGS,
    parameter int MAX_PACKET   = osc_msp_pkg::DEF_MAX_PACKET
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_end_of_packet,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output osc_msp_pkg::t_kind       o_kind,
    output logic [31:0]              o_arg_value,
    output logic [9:0]               o_string_offset,
    output logic [9:0]               o_string_length,
    output logic [2:0]               o_arg_position,
    output logic                     o_accepted,
    output logic [3:0]               o_argument_total,
    output logic [5:0]               o_address_length,
    output logic                     o_run_end
);
    import osc_msp_pkg::*;

    localparam int PW = $clog2(MAX_PACKET + 1);
    localparam int AW = $clog2(ADDRESS_SIZE + 1);
    localparam int CW = $clog2(MAX_ARGS + 1);
    localparam int XW = ((PW > AW) ? PW : AW) + 2;
    localparam int QD = 4;
    localparam int QW = $clog2(QD);

    localparam logic [2:0] PH_ADDR  = 3'd0;
    localparam logic [2:0] PH_APAD  = 3'd1;
    localparam logic [2:0] PH_COMMA = 3'd2;
    localparam logic [2:0] PH_TAGS  = 3'd3;
    localparam logic [2:0] PH_TPAD  = 3'd4;
    localparam logic [2:0] PH_ARGS  = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;

    logic [PW-1:0] r_pos, n_pos;
    logic [2:0]    r_phase, n_phase;
    logic [AW-1:0] r_addr, n_addr;
    logic [CW-1:0] r_tag_total, n_tag_total;
    logic [PW-1:0] r_tag_chars, n_tag_chars;
    logic [CW-1:0] r_cur, n_cur;
    logic [31:0]   r_word, n_word;
    logic [PW-1:0] r_sstart, n_sstart;
    logic [PW-1:0] r_schars, n_schars;
    logic [CW-1:0] r_parsed, n_parsed;
    logic          r_rej, n_rej;
    logic          r_null, n_null;
    logic [XW-1:0] r_tend, n_tend;

    t_tag          r_tags [MAX_ARGS+1];
    logic          w_tag_we;
    logic          w_tag_shift;
    t_tag          w_tag_code;

    t_result       r_queue [QD];
    logic [QW-1:0] r_wptr, r_rptr;
    logic [QW:0]   r_count;

    logic          w_in_fire;
    logic          w_out_fire;
    logic [XW-1:0] w_pos1;
    logic [XW-1:0] w_pad_addr;
    logic [XW-1:0] w_pad_tags;
    logic [XW-1:0] w_pad_str;
    logic [XW-1:0] w_rel;
    logic          w_begin;
    logic [CW-1:0] w_begin_cur;
    t_tag          w_begin_tag;
    logic          w_done;
    t_tag          w_cur_tag;
    logic          w_arg_push;
    t_result       w_arg;
    t_result       w_stat;
    logic          w_ok;
    t_result       w_first;
    t_result       w_second;
    logic [1:0]    w_npush;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_fire = o_out_valid && i_out_ready;
    assign o_in_ready = (r_count <= (QW+1)'(QD - 2));
    assign o_out_valid = (r_count != '0);

    assign w_pos1     = XW'(r_pos) + XW'(1);
    assign w_pad_addr = (XW'(r_addr) & ~XW'(3)) + XW'(4);
    assign w_pad_tags = (XW'(r_tag_chars) & ~XW'(3)) + XW'(4);
    assign w_pad_str  = (XW'(r_schars) & ~XW'(3)) + XW'(4);
    assign w_rel      = XW'(r_pos) - XW'(r_sstart);
    assign w_cur_tag  = r_tags[0];

    always_comb begin
        n_pos       = r_pos;
        n_phase     = r_phase;
        n_addr      = r_addr;
        n_tag_total = r_tag_total;
        n_tag_chars = r_tag_chars;
        n_cur       = r_cur;
        n_word      = r_word;
        n_sstart    = r_sstart;
        n_schars    = r_schars;
        n_parsed    = r_parsed;
        n_rej       = r_rej;
        n_null      = r_null;
        n_tend      = r_tend;
        w_tag_we    = 1'b0;
        w_tag_shift = 1'b0;
        w_tag_code  = TAG_OTHER;
        w_begin     = 1'b0;
        w_begin_cur = r_cur;
        w_begin_tag = r_tags[0];
        w_done      = 1'b0;
        w_arg_push  = 1'b0;
        w_arg       = '0;
        w_stat      = '0;
        w_ok        = 1'b0;

        if (w_in_fire) begin
            if (r_pos >= PW'(MAX_PACKET)) begin
                n_rej = 1'b1;
            end
            if (!n_rej) begin
                unique case (r_phase)
                    PH_ADDR: begin
                        if ((r_pos == '0) && (i_data_byte != CH_SLASH)) begin
                            n_rej = 1'b1;
                        end else if (i_data_byte == CH_NULL) begin
                            n_phase = (w_pos1 == w_pad_addr) ? PH_COMMA : PH_APAD;
                        end else begin
                            n_addr = r_addr + AW'(1);
                            if (n_addr >= AW'(ADDRESS_SIZE)) begin
                                n_rej = 1'b1;
                            end
                        end
                    end
                    PH_APAD: begin
                        if (w_pos1 == w_pad_addr) begin
                            n_phase = PH_COMMA;
                        end
                    end
                    PH_COMMA: begin
                        if (i_data_byte != CH_COMMA) begin
                            n_rej = 1'b1;
                        end else begin
                            n_tag_chars = PW'(1);
                            n_phase     = PH_TAGS;
                        end
                    end
                    PH_TAGS: begin
                        if (i_data_byte == CH_NULL) begin
                            n_tend = w_pad_addr + w_pad_tags;
                            if (w_pos1 == n_tend) begin
                                w_begin = 1'b1;
                            end else begin
                                n_phase = PH_TPAD;
                            end
                        end else begin
                            if (r_tag_total < CW'(MAX_ARGS)) begin
                                case (i_data_byte)
                                    CH_INT:   w_tag_code = TAG_INT;
                                    CH_FLOAT: w_tag_code = TAG_FLOAT;
                                    CH_STR:   w_tag_code = TAG_STR;
                                    default:  w_tag_code = TAG_OTHER;
                                endcase
                                w_tag_we    = 1'b1;
                                n_tag_total = r_tag_total + CW'(1);
                            end
                            n_tag_chars = r_tag_chars + PW'(1);
                        end
                    end
                    PH_TPAD: begin
                        if (w_pos1 == r_tend) begin
                            w_begin = 1'b1;
                        end
                    end
                    PH_ARGS: begin
                        if (w_cur_tag == TAG_STR) begin
                            if (!r_null) begin
                                if (i_data_byte == CH_NULL) begin
                                    n_null = 1'b1;
                                end else begin
                                    n_schars = r_schars + PW'(1);
                                end
                            end
                            if (n_null && ((w_rel + XW'(1)) == w_pad_str)) begin
                                w_done             = 1'b1;
                                w_arg.kind          = KIND_STR;
                                w_arg.string_offset = 10'(r_sstart);
                                w_arg.string_length = 10'(r_schars);
                            end
                        end else begin
                            n_word = {r_word[23:0], i_data_byte};
                            if (w_rel == XW'(3)) begin
                                w_done          = 1'b1;
                                w_arg.kind      = t_kind'(w_cur_tag);
                                w_arg.arg_value = n_word;
                            end
                        end
                        if (w_done) begin
                            w_arg.arg_position = 3'(r_cur);
                            w_arg_push  = 1'b1;
                            w_tag_shift = 1'b1;
                            n_cur       = r_cur + CW'(1);
                            n_parsed    = r_parsed + CW'(1);
                            w_begin     = 1'b1;
                            w_begin_cur = n_cur;
                            w_begin_tag = r_tags[1];
                        end
                    end
                    PH_DONE: begin
                    end
                    default: begin
                    end
                endcase
            end

            if (w_begin) begin
                if ((w_begin_cur >= r_tag_total) || (w_begin_tag == TAG_OTHER)) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase  = PH_ARGS;
                    n_sstart = PW'(w_pos1);
                    n_schars = '0;
                    n_word   = '0;
                    n_null   = 1'b0;
                end
            end

            if (r_pos < PW'(MAX_PACKET)) begin
                n_pos = r_pos + PW'(1);
            end

            if (i_end_of_packet) begin
                w_ok = !n_rej && ((n_phase == PH_ARGS) || (n_phase == PH_DONE));
                w_stat.kind           = KIND_STATUS;
                w_stat.accepted       = w_ok;
                w_stat.argument_total = w_ok ? 4'(n_parsed) : 4'd0;
                w_stat.address_length = w_ok ? 6'(n_addr) : 6'd0;
                w_stat.run_end        = 1'b1;
                n_pos       = '0;
                n_phase     = PH_ADDR;
                n_addr      = '0;
                n_tag_total = '0;
                n_tag_chars = '0;
                n_cur       = '0;
                n_word      = '0;
                n_sstart    = '0;
                n_schars    = '0;
                n_parsed    = '0;
                n_rej       = 1'b0;
                n_null      = 1'b0;
                n_tend      = '0;
            end else begin
                w_arg.run_end = 1'b1;
            end
        end
    end

    always_comb begin
        w_first  = w_arg_push ? w_arg : w_stat;
        w_second = w_stat;
        w_npush  = '0;
        if (w_in_fire) begin
            w_npush = (w_arg_push && i_end_of_packet) ? 2'd2 :
                      ((w_arg_push || i_end_of_packet) ? 2'd1 : 2'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_phase     <= PH_ADDR;
            r_addr      <= '0;
            r_tag_total <= '0;
            r_tag_chars <= '0;
            r_cur       <= '0;
            r_word      <= '0;
            r_sstart    <= '0;
            r_schars    <= '0;
            r_parsed    <= '0;
            r_rej       <= 1'b0;
            r_null      <= 1'b0;
            r_tend      <= '0;
        end else begin
            r_pos       <= n_pos;
            r_phase     <= n_phase;
            r_addr      <= n_addr;
            r_tag_total <= n_tag_total;
            r_tag_chars <= n_tag_chars;
            r_cur       <= n_cur;
            r_word      <= n_word;
            r_sstart    <= n_sstart;
            r_schars    <= n_schars;
            r_parsed    <= n_parsed;
            r_rej       <= n_rej;
            r_null      <= n_null;
            r_tend      <= n_tend;
        end
    end

    // tag store: filled in order, shifted down as each argument completes
    always_ff @(posedge i_clk) begin
        if (w_tag_shift) begin
            for (int i = 0; i < MAX_ARGS; i++) begin
                r_tags[i] <= r_tags[i+1];
            end
            r_tags[MAX_ARGS] <= TAG_OTHER;
        end else if (w_tag_we) begin
            r_tags[r_tag_total] <= w_tag_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_npush != 2'd0) begin
            r_queue[r_wptr] <= w_first;
        end
        if (w_npush == 2'd2) begin
            r_queue[r_wptr + QW'(1)] <= w_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + QW'(w_npush);
            r_rptr  <= r_rptr + QW'(w_out_fire);
            r_count <= r_count + (QW+1)'(w_npush) - (QW+1)'(w_out_fire);
        end
    end

    assign o_kind           = r_queue[r_rptr].kind;
    assign o_arg_value      = r_queue[r_rptr].arg_value;
    assign o_string_offset  = r_queue[r_rptr].string_offset;
    assign o_string_length  = r_queue[r_rptr].string_length;
    assign o_arg_position   = r_queue[r_rptr].arg_position;
    assign o_accepted       = r_queue[r_rptr].accepted;
    assign o_argument_total = r_queue[r_rptr].argument_total;
    assign o_address_length = r_queue[r_rptr].address_length;
    assign o_run_end        = r_queue[r_rptr].run_end;

endmodule
